// ===== design/esb_pkg.sv =====
// Shared types, codes and widths for the engine supervisor with retry backoff.
`default_nettype none

package esb_pkg;

    // Field widths
    localparam int FuncW   = 3;
    localparam int TimeW   = 32;
    localparam int DelayW  = 16;
    localparam int EpochW  = 29;
    localparam int CountW  = 32;
    localparam int CfgIdxW = 2;
    localparam int OutW    = 120;

    // Event codes
    localparam logic [FuncW-1:0] FUNC_START    = 3'd0;
    localparam logic [FuncW-1:0] FUNC_STOP     = 3'd1;
    localparam logic [FuncW-1:0] FUNC_RESTART  = 3'd2;
    localparam logic [FuncW-1:0] FUNC_RUNNING  = 3'd3;
    localparam logic [FuncW-1:0] FUNC_STOPPED  = 3'd4;
    localparam logic [FuncW-1:0] FUNC_FAILED   = 3'd5;
    localparam logic [FuncW-1:0] FUNC_FETCH    = 3'd6;
    localparam logic [FuncW-1:0] FUNC_QUERY    = 3'd7;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_FIRST_DELAY    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_DELAY      = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_HEALTHY_UPTIME = 2'd2;

    // Configuration reset values
    localparam logic [DelayW-1:0] FIRST_DELAY_RST    = 16'd5;
    localparam logic [DelayW-1:0] MAX_DELAY_RST      = 16'd300;
    localparam logic [DelayW-1:0] HEALTHY_UPTIME_RST = 16'd60;

    typedef struct packed {
        logic [DelayW-1:0] first_delay;
        logic [DelayW-1:0] max_delay;
        logic [DelayW-1:0] healthy_uptime;
    } cfg_t;

    typedef struct packed {
        logic [FuncW-1:0] func;
        logic [TimeW-1:0] now_seconds;
    } event_t;

    typedef struct packed {
        logic              is_running;
        logic              is_desired;
        logic              is_retrying;
        logic [EpochW-1:0] epoch;
        logic [TimeW-1:0]  uptime;
        logic [DelayW-1:0] fetched_delay;
        logic              stop_request;
        logic              wake;
        logic [CountW-1:0] command_count;
    } result_t;

endpackage

`default_nettype wire

// ===== design/esb_in_stage.sv =====
// Input register: holds one event request until the core consumes it.
`default_nettype none

module esb_in_stage import esb_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire event_t s_event,
    input  wire logic   advance,
    output logic        ev_valid,
    output event_t      ev
);

    logic   valid_reg;
    logic   valid_next;
    event_t ev_reg;

    // Accept when empty or when the held request moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ev_reg <= s_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

`default_nettype wire

// ===== design/esb_core.sv =====
// Supervisor state and the next-state and result logic for one event.
`default_nettype none

module esb_core import esb_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   fire,
    input  wire event_t ev,
    input  wire cfg_t   cfg,
    output result_t     res
);

    logic              want_on_reg,      want_on_next;
    logic              running_reg,      running_next;
    logic              restart_pend_reg, restart_pend_next;
    logic              retry_armed_reg,  retry_armed_next;
    logic              retry_pend_reg,   retry_pend_next;
    logic [DelayW-1:0] delay_reg,        delay_next;
    logic [EpochW-1:0] epoch_reg,        epoch_next;
    logic [TimeW-1:0]  stamp_reg,        stamp_next;
    logic [CountW-1:0] cmd_count_reg,    cmd_count_next;

    logic [TimeW-1:0]  run_len;
    logic              healthy;
    logic [DelayW:0]   doubled;
    logic [DelayW-1:0] base_delay;
    logic [DelayW-1:0] fetched;
    logic              stop_req;
    logic              wake;
    logic [EpochW-1:0] epoch_inc;
    logic [CountW-1:0] count_inc;

    assign run_len   = ev.now_seconds - stamp_reg;
    assign healthy   = running_reg && (run_len >= {{(TimeW-DelayW){1'b0}}, cfg.healthy_uptime});
    assign epoch_inc = epoch_reg + {{(EpochW-1){1'b0}}, 1'b1};
    assign count_inc = cmd_count_reg + {{(CountW-1){1'b0}}, 1'b1};
    // A healthy run restarts the backoff from the first delay
    assign base_delay = healthy ? '0 : delay_reg;
    assign doubled    = {base_delay, 1'b0};

    // Next state and result for the event at the core input
    always_comb begin
        want_on_next      = want_on_reg;
        running_next      = running_reg;
        restart_pend_next = restart_pend_reg;
        retry_armed_next  = retry_armed_reg;
        retry_pend_next   = retry_pend_reg;
        delay_next        = delay_reg;
        epoch_next        = epoch_reg;
        stamp_next        = stamp_reg;
        cmd_count_next    = cmd_count_reg;
        fetched           = '0;
        stop_req          = 1'b0;
        wake              = 1'b0;
        unique case (ev.func)
            FUNC_START: begin
                cmd_count_next   = count_inc;
                delay_next       = '0;
                retry_pend_next  = 1'b0;
                retry_armed_next = 1'b0;
                if (!want_on_reg) begin
                    want_on_next      = 1'b1;
                    restart_pend_next = 1'b0;
                    epoch_next        = epoch_inc;
                    wake              = 1'b1;
                end
            end
            FUNC_STOP: begin
                cmd_count_next    = count_inc;
                want_on_next      = 1'b0;
                restart_pend_next = 1'b0;
                delay_next        = '0;
                retry_pend_next   = 1'b0;
                retry_armed_next  = 1'b0;
                epoch_next        = epoch_inc;
                stop_req          = 1'b1;
            end
            FUNC_RESTART: begin
                cmd_count_next    = count_inc;
                want_on_next      = 1'b1;
                restart_pend_next = running_reg;
                delay_next        = '0;
                retry_pend_next   = 1'b0;
                retry_armed_next  = running_reg;
                epoch_next        = epoch_inc;
                stop_req          = running_reg;
                wake              = !running_reg;
            end
            FUNC_RUNNING: begin
                running_next     = 1'b1;
                stamp_next       = ev.now_seconds;
                retry_armed_next = 1'b0;
                epoch_next       = epoch_inc;
            end
            FUNC_STOPPED: begin
                running_next = 1'b0;
                epoch_next   = epoch_inc;
                priority if (restart_pend_reg) begin
                    restart_pend_next = 1'b0;
                end else if (want_on_reg && (running_reg || retry_armed_reg)) begin
                    // Schedule a retry with a doubled, capped delay
                    if (base_delay == '0) begin
                        delay_next = cfg.first_delay;
                    end else if (doubled < {1'b0, cfg.max_delay}) begin
                        delay_next = doubled[DelayW-1:0];
                    end else begin
                        delay_next = cfg.max_delay;
                    end
                    retry_armed_next = 1'b1;
                    retry_pend_next  = 1'b1;
                end else if (want_on_reg) begin
                    // Stopped without a run to retry: give up
                    want_on_next     = 1'b0;
                    delay_next       = '0;
                    retry_pend_next  = 1'b0;
                    retry_armed_next = 1'b0;
                end
            end
            FUNC_FAILED: begin
                restart_pend_next = 1'b0;
            end
            FUNC_FETCH: begin
                if (retry_pend_reg) begin
                    retry_pend_next = 1'b0;
                    fetched         = delay_reg;
                end
            end
            FUNC_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    // Result reflects the state after the event
    always_comb begin
        res.is_running    = running_next;
        res.is_desired    = want_on_next;
        res.is_retrying   = want_on_next && retry_armed_next && !running_next;
        res.epoch         = epoch_next;
        res.uptime        = running_next ? (ev.now_seconds - stamp_next) : '0;
        res.fetched_delay = fetched;
        res.stop_request  = stop_req;
        res.wake          = wake;
        res.command_count = cmd_count_next;
    end

    // Commit state when the event moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            want_on_reg      <= 1'b0;
            running_reg      <= 1'b0;
            restart_pend_reg <= 1'b0;
            retry_armed_reg  <= 1'b0;
            retry_pend_reg   <= 1'b0;
            delay_reg        <= '0;
            epoch_reg        <= '0;
            stamp_reg        <= '0;
            cmd_count_reg    <= '0;
        end else if (fire) begin
            want_on_reg      <= want_on_next;
            running_reg      <= running_next;
            restart_pend_reg <= restart_pend_next;
            retry_armed_reg  <= retry_armed_next;
            retry_pend_reg   <= retry_pend_next;
            delay_reg        <= delay_next;
            epoch_reg        <= epoch_next;
            stamp_reg        <= stamp_next;
            cmd_count_reg    <= cmd_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/esb_out_stage.sv =====
// Result register: holds one result request until the sink takes it.
`default_nettype none

module esb_out_stage import esb_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t res,
    input  wire logic    m_ready,
    output logic         m_valid,
    output result_t      m_res,
    output logic         can_load
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new result when one is produced
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

// ===== design/engine_supervisor_backoff.sv =====
// Top level: engine supervisor with capped exponential retry backoff.
// An accepted event is held in the input register, then in the result register.
// Throughput: one event per cycle unless the sink stalls the result register.
// Both stages are skid-free registers that accept while the downstream one drains.
// Reset (aresetn low, synchronous) clears all flags, epoch, counters and delay,
// and loads the configuration registers with their default values.
`default_nettype none

module engine_supervisor_backoff import esb_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Event requests
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TimeW-1:0]     s_tdata,   // [31:0] now_seconds
    input  wire logic [FuncW-1:0]     s_tuser,   // [2:0] func
    // Results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] is_running, [1] is_desired, [2] is_retrying, [31:3] epoch,
    // [63:32] uptime, [79:64] fetched_delay, [80] stop_request, [81] wake,
    // [113:82] command_count, [119:114] zero
    output logic [OutW-1:0]           m_tdata,
    // Configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]   cfg_index,
    input  wire logic [DelayW-1:0]    cfg_wdata
);

    cfg_t    cfg_reg;
    event_t  s_event;
    event_t  ev;
    logic    ev_valid;
    logic    can_load;
    logic    advance;
    result_t res;
    result_t m_res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_delay    <= FIRST_DELAY_RST;
            cfg_reg.max_delay      <= MAX_DELAY_RST;
            cfg_reg.healthy_uptime <= HEALTHY_UPTIME_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FIRST_DELAY:    cfg_reg.first_delay    <= cfg_wdata;
                CFG_MAX_DELAY:      cfg_reg.max_delay      <= cfg_wdata;
                CFG_HEALTHY_UPTIME: cfg_reg.healthy_uptime <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_event.func        = s_tuser;
    assign s_event.now_seconds = s_tdata;

    // Move the held event through the core when the result register has room
    assign advance = ev_valid && can_load;

    esb_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_event  (s_event),
        .advance  (advance),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    esb_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .ev      (ev),
        .cfg     (cfg_reg),
        .res     (res)
    );

    esb_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res      (res),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_res    (m_res),
        .can_load (can_load)
    );

    assign m_tdata = {6'd0, m_res.command_count, m_res.wake, m_res.stop_request,
                      m_res.fetched_delay, m_res.uptime, m_res.epoch,
                      m_res.is_retrying, m_res.is_desired, m_res.is_running};

    // Retrying only while desired and not running
    a_retry_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && (!m_tdata[1] || m_tdata[0])))
        else $error("retrying flag set while not desired or running");

    // No uptime while stopped
    a_uptime_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[63:32] == '0))
        else $error("uptime nonzero while stopped");

    // Input stalls only when both stages are full and the sink is stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (ev_valid && m_tvalid && !m_tready))
        else $error("input stalled without backpressure");

    // An event that leaves the core shows up as a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result lost after core");

endmodule

`default_nettype wire
